>>> hdl/scfp_pkg.sv
package scfp_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 5;
    localparam int CFG_IDX_W = 1;

    // Default frame payload length
    localparam int FRAME_BYTES_DEF = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 1'd1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'h24;
    localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'h7C;

    // Character constants
    localparam logic [BYTE_W-1:0] DIGIT_LO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_HI = 8'h39;
    localparam logic [BYTE_W-1:0] NEWLINE  = 8'h0A;

    // Reply byte positions
    localparam logic [1:0] REPLY_HUND  = 2'd0;
    localparam logic [1:0] REPLY_TENS  = 2'd1;
    localparam logic [1:0] REPLY_ONES  = 2'd2;
    localparam logic [1:0] REPLY_LAST  = 2'd3;

    // Result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] sensor_reading;
    } t_in_item;

    typedef struct packed {
        logic               out_kind;
        logic [BYTE_W-1:0]  out_byte;
        logic [INDEX_W-1:0] out_index;
        logic               out_last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic cnt_clr;
        logic store_wr;
        logic cap_reading;
        logic idx_clr;
        logic rd_en;
        logic load_reply;
        logic load_frame;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_start;
        logic is_digit;
        logic is_end;
        logic cnt_full;
        logic reply_last;
        logic frame_last;
        logic out_free;
    } t_status;

endpackage

>>> hdl/serial_command_frame_parser_core.sv
// Serial command frame parser.
// Input channel (i_in_valid / o_in_ready / i_in) carries one host byte per
// transaction with the sensor reading beside it. Output channel
// (o_out_valid / i_out_ready / o_out) carries reply bytes to the host and
// display frame bytes, each tagged with its kind, index and a last flag.
// Configuration: i_cfg_we writes i_cfg_data to start_char (index 0) or
// end_char (index 1); write only while the block is idle.
// Flow: a byte that produces no result leaves the parser ready and the next byte
// may follow immediately. A digit query is answered with four reply bytes,
// one per cycle while the receiver accepts them; the input is held off
// until the last is in the output register. A closed frame replays its
// bytes from the frame store, each read from the store and then loaded
// into the output register, with the input held off meanwhile.
// Reset (synchronous, active low) returns the parser to idle outside any
// frame and restores the default start and end characters; store contents
// are not cleared. When the receiver stalls, the output register holds its
// transaction and emission pauses; no result is lost.
module serial_command_frame_parser_core #(
    parameter int FRAME_BYTES = scfp_pkg::FRAME_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [scfp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scfp_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  scfp_pkg::t_in_item             i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output scfp_pkg::t_out_item            o_out
);
    import scfp_pkg::*;

    t_cmd    cmd;
    t_status status;

    scfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    scfp_dpath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

>>> hdl/scfp_dpath.sv
module scfp_dpath #(
    parameter int FRAME_BYTES = scfp_pkg::FRAME_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [scfp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [scfp_pkg::BYTE_W-1:0]         i_cfg_data,
    input  scfp_pkg::t_in_item                  i_in,
    input  scfp_pkg::t_cmd                      i_cmd,
    output scfp_pkg::t_status                   o_status,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output scfp_pkg::t_out_item                 o_out
);
    import scfp_pkg::*;

    localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CW = $clog2(FRAME_BYTES + 1);

    logic [BYTE_W-1:0]  r_start_char;
    logic [BYTE_W-1:0]  r_end_char;
    logic [CW-1:0]      r_count;
    logic [INDEX_W-1:0] r_idx;
    logic [1:0]         r_hund;
    logic [6:0]         r_rem;
    logic [BYTE_W-1:0]  r_store [FRAME_BYTES];
    logic [BYTE_W-1:0]  r_rd_data;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [1:0]         n_hund;
    logic [BYTE_W-1:0]  n_rem;
    logic [14:0]        tens_prod;
    logic [3:0]         tens;
    logic [3:0]         ones;
    logic [BYTE_W-1:0]  reply_byte;
    logic               frame_last;
    logic               out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= START_CHAR_RST;
            r_end_char   <= END_CHAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START_CHAR: r_start_char <= i_cfg_data;
                REG_END_CHAR:   r_end_char   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Split the reading into a hundreds digit and a remainder below 100
    always_comb begin
        priority if (i_in.sensor_reading >= 8'd200) begin
            n_hund = 2'd2;
            n_rem  = i_in.sensor_reading - 8'd200;
        end else if (i_in.sensor_reading >= 8'd100) begin
            n_hund = 2'd1;
            n_rem  = i_in.sensor_reading - 8'd100;
        end else begin
            n_hund = 2'd0;
            n_rem  = i_in.sensor_reading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_reading) begin
            r_hund <= n_hund;
            r_rem  <= n_rem[6:0];
        end
    end

    // Tens by reciprocal multiply (exact below 100), ones by subtraction
    assign tens_prod = 15'(r_rem) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones      = 4'(r_rem - 7'(tens) * 7'd10);

    always_comb begin
        unique case (r_idx[1:0])
            REPLY_HUND: reply_byte = DIGIT_LO + 8'(r_hund);
            REPLY_TENS: reply_byte = DIGIT_LO + 8'(tens);
            REPLY_ONES: reply_byte = DIGIT_LO + 8'(ones);
            REPLY_LAST: reply_byte = NEWLINE;
            default:    reply_byte = NEWLINE;
        endcase
    end

    // Payload counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_count <= '0;
        end else if (i_cmd.store_wr) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Frame store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr) begin
            r_store[r_count[AW-1:0]] <= i_in.rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_store[r_idx[AW-1:0]];
        end
    end

    // Emit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.load_reply || i_cmd.load_frame) begin
            r_idx <= r_idx + INDEX_W'(1);
        end
    end

    assign frame_last = (r_idx == INDEX_W'(FRAME_BYTES - 1));
    assign out_free   = !r_out_valid || i_out_ready;

    // Output register: load a result, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_reply || i_cmd.load_frame) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_reply) begin
            r_out.out_kind  <= KIND_REPLY;
            r_out.out_byte  <= reply_byte;
            r_out.out_index <= r_idx;
            r_out.out_last  <= (r_idx[1:0] == REPLY_LAST);
        end else if (i_cmd.load_frame) begin
            r_out.out_kind  <= KIND_FRAME;
            r_out.out_byte  <= r_rd_data;
            r_out.out_index <= r_idx;
            r_out.out_last  <= frame_last;
        end
    end

    // Status to controller
    assign o_status.is_start   = (i_in.rx_byte == r_start_char);
    assign o_status.is_digit   = (i_in.rx_byte >= DIGIT_LO) && (i_in.rx_byte <= DIGIT_HI);
    assign o_status.is_end     = (i_in.rx_byte == r_end_char);
    assign o_status.cnt_full   = (r_count >= CW'(FRAME_BYTES));
    assign o_status.reply_last = (r_idx[1:0] == REPLY_LAST);
    assign o_status.frame_last = frame_last;
    assign o_status.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> hdl/scfp_ctrl.sv
module scfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  scfp_pkg::t_status i_status,
    output scfp_pkg::t_cmd    o_cmd
);
    import scfp_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FRAME   = 3'd1;
    localparam logic [2:0] S_REPLY   = 3'd2;
    localparam logic [2:0] S_PLAY_RD = 3'd3;
    localparam logic [2:0] S_PLAY_WR = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE) || (r_state == S_FRAME);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_status.is_start) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_FRAME;
                    end else if (i_status.is_digit) begin
                        o_cmd.cap_reading = 1'b1;
                        o_cmd.idx_clr     = 1'b1;
                        n_state           = S_REPLY;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FRAME: begin
                if (accept) begin
                    if (i_status.cnt_full) begin
                        o_cmd.cnt_clr = 1'b1;
                        if (i_status.is_end) begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_PLAY_RD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_cmd.store_wr = 1'b1;
                    end
                end
            end
            S_REPLY: begin
                if (i_status.out_free) begin
                    o_cmd.load_reply = 1'b1;
                    if (i_status.reply_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PLAY_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_PLAY_WR;
            end
            S_PLAY_WR: begin
                if (i_status.out_free) begin
                    o_cmd.load_frame = 1'b1;
                    n_state = i_status.frame_last ? S_IDLE : S_PLAY_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // A frame byte is loaded only after its store read was issued
    a_play_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLAY_WR) |->
            ($past(r_state) == S_PLAY_RD || $past(r_state) == S_PLAY_WR))
        else $error("frame emit without a preceding store read");

    // A bad closing byte drops the frame and returns to idle
    a_drop_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAME && accept && i_status.cnt_full && !i_status.is_end)
            |=> (r_state == S_IDLE))
        else $error("dropped frame did not return to idle");

    // No payload write once the frame is complete
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.store_wr |-> !i_status.cnt_full)
        else $error("frame store written past its length");

    // Input is never taken while results are being emitted
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_reply || o_cmd.load_frame) |-> !o_in_ready)
        else $error("input accepted during result emission");
`endif

endmodule
